// File: rtl/core/qlu_pkg.sv
// Shared types, constants and microcode ROM for the Q-table update block.
package qlu_pkg;

    localparam int DEF_STATES      = 64;
    localparam int DEF_ACTIONS     = 4;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int STATE_W   = 6;
    localparam int ACTION_W  = 2;
    localparam int FIX_W     = 32;
    localparam int COEF_W    = 17;
    localparam int SIU_W     = 7;
    localparam int AIU_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 40;

    localparam logic [COEF_W-1:0] COEF_ONE     = 17'd65536;
    localparam logic [COEF_W-1:0] RST_LR       = 17'd6554;
    localparam logic [COEF_W-1:0] RST_DISCOUNT = 17'd58982;
    localparam logic [SIU_W-1:0]  RST_STATES   = 7'd64;
    localparam logic [AIU_W-1:0]  RST_ACTIONS  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE,
        REG_DISCOUNT,
        REG_STATES_IN_USE,
        REG_ACTIONS_IN_USE
    } cfg_reg_t;

    typedef enum logic [3:0] {
        UP_IDLE,
        UP_SCAN0,
        UP_SCAN,
        UP_READQ,
        UP_MULG,
        UP_TD,
        UP_MULA,
        UP_WRITE,
        UP_CLEAR
    } upc_t;

    typedef enum logic [1:0] {HOLD_NONE, HOLD_NO_INPUT, HOLD_OUT_BUSY} hold_t;
    typedef enum logic [1:0] {JMP_NONE, JMP_IDX_ERR, JMP_SCAN_MORE, JMP_CLR_MORE} jump_t;
    typedef enum logic [1:0] {ADR_SCAN, ADR_NOW, ADR_CLR} addr_t;
    typedef enum logic [1:0] {XS_HOLD, XS_SHAPED, XS_TD} xsel_t;
    typedef enum logic {CF_GAMMA, CF_ALPHA} coef_t;

    typedef struct packed {
        hold_t hold;
        jump_t jump;
        upc_t  target;
        upc_t  next;
        addr_t addr;
        logic  mem_rd;
        logic  mem_wr;
        logic  in_ready;
        logic  scan_cmp;
        logic  ld_q;
        xsel_t xsel;
        logic  mul_en;
        coef_t coef;
        logic  out_ld;
    } ctrl_t;

    function automatic ctrl_t ucode(upc_t pc);
        ctrl_t c;
        c = '0;
        c.next   = UP_IDLE;
        c.target = UP_IDLE;
        case (pc)
            UP_IDLE: begin
                c.hold     = HOLD_NO_INPUT;
                c.jump     = JMP_IDX_ERR;
                c.target   = UP_WRITE;
                c.next     = UP_SCAN0;
                c.in_ready = 1'b1;
            end
            UP_SCAN0: begin
                c.addr   = ADR_SCAN;
                c.mem_rd = 1'b1;
                c.next   = UP_SCAN;
            end
            UP_SCAN: begin
                c.addr     = ADR_SCAN;
                c.mem_rd   = 1'b1;
                c.scan_cmp = 1'b1;
                c.jump     = JMP_SCAN_MORE;
                c.target   = UP_SCAN;
                c.next     = UP_READQ;
            end
            UP_READQ: begin
                c.addr   = ADR_NOW;
                c.mem_rd = 1'b1;
                c.xsel   = XS_SHAPED;
                c.next   = UP_MULG;
            end
            UP_MULG: begin
                c.ld_q   = 1'b1;
                c.mul_en = 1'b1;
                c.coef   = CF_GAMMA;
                c.next   = UP_TD;
            end
            UP_TD: begin
                c.xsel = XS_TD;
                c.next = UP_MULA;
            end
            UP_MULA: begin
                c.mul_en = 1'b1;
                c.coef   = CF_ALPHA;
                c.next   = UP_WRITE;
            end
            UP_WRITE: begin
                c.hold   = HOLD_OUT_BUSY;
                c.addr   = ADR_NOW;
                c.mem_wr = 1'b1;
                c.out_ld = 1'b1;
                c.next   = UP_IDLE;
            end
            UP_CLEAR: begin
                c.addr   = ADR_CLR;
                c.mem_wr = 1'b1;
                c.jump   = JMP_CLR_MORE;
                c.target = UP_CLEAR;
                c.next   = UP_IDLE;
            end
            default: begin
                c.next = UP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/q_learning_table_update.sv
// Q-table update block: microcoded sequencer over a single-port value memory.
//
// Usage:
//   s_ channel: one request per experience (states, action, reward, potentials).
//   m_ channel: one result per request (updated value, greedy next action, error).
//   cfg port: write-only registers, written while the block is idle.
// Sequence: after accept, the step counter walks the table reads for the argmax over
//   A actions, where A is actions_in_use capped at ACTIONS, then does one read, two
//   dependent multiplies through a single multiplier, and one write. A request with
//   an index error goes from the accept step straight to the write-back step and
//   leaves the table untouched.
//   One request is in flight at a time; s_tready is high only in the idle step.
// Reset: registers take their reset values, then a clearing pass writes zero
//   to every one of the 2**clog2(STATES) * 2**clog2(ACTIONS) table entries
//   (256 at default), with s_tready low.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and the write-back step holds until that register frees.
module q_learning_table_update #(
    parameter int STATES      = qlu_pkg::DEF_STATES,
    parameter int ACTIONS     = qlu_pkg::DEF_ACTIONS,
    parameter int VALUE_WIDTH = qlu_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [qlu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qlu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // state_now, action_taken, state_next, reward, potential_now, potential_next
    input  logic [qlu_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // new_value, best_next_action
    output logic [qlu_pkg::M_TDATA_W-1:0]   m_tdata,
    // index_error
    output logic                            m_tuser
);
    import qlu_pkg::*;

    localparam int SIW   = $clog2(STATES);
    localparam int AIW   = $clog2(ACTIONS);
    localparam int MAW   = SIW + AIW;
    localparam int DEPTH = 1 << MAW;
    localparam int SCW   = ($clog2(STATES + 1) > SIU_W) ? $clog2(STATES + 1) : SIU_W;
    localparam int ACW   = ($clog2(ACTIONS + 1) > AIU_W) ? $clog2(ACTIONS + 1) : AIU_W;
    localparam int VW    = VALUE_WIDTH;
    localparam int XW    = ((VW > FIX_W) ? VW : FIX_W) + 3;
    localparam int PW    = XW + COEF_W + 1;

    localparam logic signed [XW-1:0] VMAX = {{(XW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN = {{(XW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

    // configuration
    logic [COEF_W-1:0] lr_reg, lr_next;
    logic [COEF_W-1:0] disc_reg, disc_next;
    logic [SIU_W-1:0]  siu_reg, siu_next;
    logic [AIU_W-1:0]  aiu_reg, aiu_next;

    always_comb begin
        lr_next   = lr_reg;
        disc_next = disc_reg;
        siu_next  = siu_reg;
        aiu_next  = aiu_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_LEARNING_RATE:  lr_next   = cfg_wdata;
                REG_DISCOUNT:       disc_next = cfg_wdata;
                REG_STATES_IN_USE:  siu_next  = cfg_wdata[SIU_W-1:0];
                REG_ACTIONS_IN_USE: aiu_next  = cfg_wdata[AIU_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SCW-1:0] eff_states;
    logic [ACW-1:0] eff_actions;
    logic [COEF_W-1:0] alpha, gamma;

    assign eff_states  = (SCW'(siu_reg) > SCW'(STATES)) ? SCW'(STATES) : SCW'(siu_reg);
    assign eff_actions = (ACW'(aiu_reg) > ACW'(ACTIONS)) ? ACW'(ACTIONS) : ACW'(aiu_reg);
    assign alpha = (lr_reg > COEF_ONE) ? COEF_ONE : lr_reg;
    assign gamma = (disc_reg > COEF_ONE) ? COEF_ONE : disc_reg;

    // input fields
    logic [STATE_W-1:0]  in_s, in_sn;
    logic [ACTION_W-1:0] in_a;
    logic [FIX_W-1:0]    in_r, in_pnow, in_pnext;
    logic [SCW-1:0]      in_s_x, in_sn_x;
    logic [ACW-1:0]      in_a_x;
    logic                in_err;

    assign in_s     = s_tdata[STATE_W-1:0];
    assign in_a     = s_tdata[STATE_W +: ACTION_W];
    assign in_sn    = s_tdata[STATE_W+ACTION_W +: STATE_W];
    assign in_r     = s_tdata[2*STATE_W+ACTION_W +: FIX_W];
    assign in_pnow  = s_tdata[2*STATE_W+ACTION_W+FIX_W +: FIX_W];
    assign in_pnext = s_tdata[2*STATE_W+ACTION_W+2*FIX_W +: FIX_W];
    assign in_s_x   = SCW'(in_s);
    assign in_sn_x  = SCW'(in_sn);
    assign in_a_x   = ACW'(in_a);
    assign in_err   = (in_s_x >= eff_states) || (in_sn_x >= eff_states)
                   || (in_a_x >= eff_actions);

    // sequencer
    upc_t  upc_reg, upc_next;
    ctrl_t ctrl;
    logic  hold, jump_taken, advance, accept;
    logic  m_valid_reg, m_valid_next;
    logic [ACW-1:0] i_reg, i_next;
    logic [MAW-1:0] clr_reg, clr_next;

    always_comb begin
        ctrl = ucode(upc_reg);
    end

    always_comb begin
        case (ctrl.hold)
            HOLD_NO_INPUT: hold = !s_tvalid;
            HOLD_OUT_BUSY: hold = m_valid_reg && !m_tready;
            default:       hold = 1'b0;
        endcase
        case (ctrl.jump)
            JMP_IDX_ERR:   jump_taken = in_err;
            JMP_SCAN_MORE: jump_taken = (i_reg < eff_actions);
            JMP_CLR_MORE:  jump_taken = (clr_reg != {MAW{1'b1}});
            default:       jump_taken = 1'b0;
        endcase
        advance = !hold;
        if (hold) begin
            upc_next = upc_reg;
        end else if (jump_taken) begin
            upc_next = ctrl.target;
        end else begin
            upc_next = ctrl.next;
        end
    end

    assign s_tready = ctrl.in_ready;
    assign accept   = s_tvalid && s_tready;

    // request registers
    logic [SIW-1:0] s_reg, sn_reg;
    logic [AIW-1:0] a_reg;
    logic signed [FIX_W-1:0] r_reg, pnow_reg, pnext_reg;
    logic err_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s_reg     <= in_s_x[SIW-1:0];
            sn_reg    <= in_sn_x[SIW-1:0];
            a_reg     <= in_a_x[AIW-1:0];
            r_reg     <= in_r;
            pnow_reg  <= in_pnow;
            pnext_reg <= in_pnext;
            err_reg   <= in_err;
        end
    end

    // memory
    logic signed [VW-1:0] qmem [DEPTH];
    logic signed [VW-1:0] rdata_reg;
    logic [MAW-1:0]       mem_addr;
    logic                 mem_we, mem_re;
    logic signed [VW-1:0] mem_wdata;
    logic signed [XW-1:0] nv_sat;

    always_comb begin
        case (ctrl.addr)
            ADR_SCAN: mem_addr = {sn_reg, i_reg[AIW-1:0]};
            ADR_NOW:  mem_addr = {s_reg, a_reg};
            ADR_CLR:  mem_addr = clr_reg;
            default:  mem_addr = clr_reg;
        endcase
    end

    assign mem_re    = ctrl.mem_rd;
    assign mem_we    = ctrl.mem_wr && advance && ((ctrl.addr == ADR_CLR) || !err_reg);
    assign mem_wdata = (ctrl.addr == ADR_CLR) ? '0 : nv_sat[VW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            qmem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= qmem[mem_addr];
        end
    end

    assign clr_next = (ctrl.addr == ADR_CLR && ctrl.mem_wr) ? clr_reg + 1'b1 : clr_reg;

    always_comb begin
        i_next = i_reg;
        if (accept) begin
            i_next = '0;
        end else if (ctrl.addr == ADR_SCAN && ctrl.mem_rd) begin
            i_next = i_reg + 1'b1;
        end
    end

    // argmax
    logic signed [VW-1:0] qmax_reg;
    logic [AIW-1:0]       best_reg;
    logic [ACW-1:0]       i_prev;

    assign i_prev = i_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (accept) begin
            best_reg <= '0;
        end else if (ctrl.scan_cmp && ((i_reg == ACW'(1)) || (rdata_reg > qmax_reg))) begin
            qmax_reg <= rdata_reg;
            best_reg <= i_prev[AIW-1:0];
        end
    end

    // arithmetic
    logic signed [VW-1:0] q_reg;
    logic signed [XW-1:0] x_reg, prod_reg;
    logic signed [XW-1:0] qmax_x, q_x, r_x, pnow_x, pnext_x, sum_x;
    logic signed [PW-1:0] prod_full;
    logic [COEF_W-1:0]    coef;

    assign qmax_x  = {{(XW - VW){qmax_reg[VW-1]}}, qmax_reg};
    assign q_x     = {{(XW - VW){q_reg[VW-1]}}, q_reg};
    assign r_x     = {{(XW - FIX_W){r_reg[FIX_W-1]}}, r_reg};
    assign pnow_x  = {{(XW - FIX_W){pnow_reg[FIX_W-1]}}, pnow_reg};
    assign pnext_x = {{(XW - FIX_W){pnext_reg[FIX_W-1]}}, pnext_reg};
    assign coef    = (ctrl.coef == CF_ALPHA) ? alpha : gamma;
    assign prod_full = x_reg * $signed({1'b0, coef});
    assign sum_x   = q_x + prod_reg;
    assign nv_sat  = (sum_x > VMAX) ? VMAX : ((sum_x < VMIN) ? VMIN : sum_x);

    always_ff @(posedge aclk) begin
        if (ctrl.ld_q) begin
            q_reg <= rdata_reg;
        end
        case (ctrl.xsel)
            XS_SHAPED: x_reg <= qmax_x + pnext_x;
            XS_TD:     x_reg <= r_x + prod_reg - q_x - pnow_x;
            default:   x_reg <= x_reg;
        endcase
        if (ctrl.mul_en) begin
            prod_reg <= prod_full[XW+15:16];
        end
    end

    // result register
    logic [FIX_W-1:0]    m_value_reg;
    logic [ACTION_W-1:0] m_best_reg;
    logic                m_err_reg;
    logic                out_load;

    assign out_load     = ctrl.out_ld && advance;
    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= err_reg ? '0 : nv_sat[FIX_W-1:0];
            m_best_reg  <= err_reg ? '0 : ACTION_W'(best_reg);
            m_err_reg   <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= UP_CLEAR;
            clr_reg     <= '0;
            i_reg       <= '0;
            m_valid_reg <= 1'b0;
            lr_reg      <= RST_LR;
            disc_reg    <= RST_DISCOUNT;
            siu_reg     <= RST_STATES;
            aiu_reg     <= RST_ACTIONS;
        end else begin
            upc_reg     <= upc_next;
            clr_reg     <= clr_next;
            i_reg       <= i_next;
            m_valid_reg <= m_valid_next;
            lr_reg      <= lr_next;
            disc_reg    <= disc_next;
            siu_reg     <= siu_next;
            aiu_reg     <= aiu_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - FIX_W - ACTION_W){1'b0}}, m_best_reg, m_value_reg};
    assign m_tuser  = m_err_reg;

endmodule

// File: rtl/core/qlu_checker.sv
// Port-level checks for the Q-table update block, bound to the top level.
module qlu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [qlu_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import qlu_pkg::*;

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken right after reset");

    // one request in flight
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken back to back");

    // error results carry zero value and action
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[FIX_W+ACTION_W-1:0] == '0)
        else $error("error result with nonzero payload");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind q_learning_table_update qlu_checker u_qlu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/tb.sv
// Self-checking testbench for q_learning_table_update: directed table, then random phases.
module tb;
    import qlu_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [STATE_W-1:0]  state_now;
        logic [ACTION_W-1:0] action_taken;
        logic [STATE_W-1:0]  state_next;
        logic [FIX_W-1:0]    reward;
        logic [FIX_W-1:0]    potential_now;
        logic [FIX_W-1:0]    potential_next;
    } experience_t;

    typedef struct packed {
        logic [FIX_W-1:0]    new_value;
        logic [ACTION_W-1:0] best_next_action;
        logic                index_error;
    } q_result_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] wdata;
        experience_t           item;
        logic                  typed;
        q_result_t             want;
    } step_row_t;

    localparam int EXP_W = 2 * STATE_W + ACTION_W + 3 * FIX_W;
    localparam logic [FIX_W-1:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [FIX_W-1:0] FIX_MIN = 32'h8000_0000;
    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;
    localparam q_result_t ZERO_RESULT = '0;
    localparam q_result_t ERR_RESULT = '{new_value: '0, best_next_action: '0, index_error: 1'b1};
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 200;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // state_now, action_taken, state_next, reward, potential_now, potential_next
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // new_value, best_next_action
    logic [M_TDATA_W-1:0]  m_tdata;
    // index_error
    logic                  m_tuser;

    // shadow of the table and registers
    logic [FIX_W-1:0]  q_table [DEF_STATES*DEF_ACTIONS];
    logic [COEF_W-1:0] alpha_reg = RST_LR;
    logic [COEF_W-1:0] gamma_reg = RST_DISCOUNT;
    logic [SIU_W-1:0]  states_reg = RST_STATES;
    logic [AIU_W-1:0]  actions_reg = RST_ACTIONS;

    q_result_t pending_results[$];
    int        fail_count = 0;
    int        burst_left = 0;
    int        hold_asked = 0;
    int        hold_served = 0;
    int        hold_cnt = 0;
    logic [5:0] pattern_cnt = '0;
    int        ready_pct = 100;

    always #2 aclk = ~aclk;

    q_learning_table_update i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic int eff_states();
        return (states_reg > DEF_STATES) ? DEF_STATES : int'(states_reg);
    endfunction

    function automatic int eff_actions();
        return (actions_reg > DEF_ACTIONS) ? DEF_ACTIONS : int'(actions_reg);
    endfunction

    // floor(x * k / 2^16), k clipped to 1.0
    function automatic longint scale_q16(longint x, logic [COEF_W-1:0] k);
        logic [COEF_W-1:0] kc;
        kc = (k > COEF_ONE) ? COEF_ONE : k;
        return (x * longint'(kc)) >>> 16;
    endfunction

    function automatic q_result_t apply_experience(experience_t e);
        q_result_t res;
        int        ns, na, slot;
        longint    qmax, qcur, v, td;
        res = '0;
        ns = eff_states();
        na = eff_actions();
        if (e.state_now >= ns || e.state_next >= ns || e.action_taken >= na) begin
            res.index_error = 1'b1;
            return res;
        end
        qmax = longint'($signed(q_table[e.state_next * DEF_ACTIONS]));
        for (int i = 1; i < na; i++) begin
            v = longint'($signed(q_table[e.state_next * DEF_ACTIONS + i]));
            if (v > qmax) begin
                qmax = v;
                res.best_next_action = ACTION_W'(i);
            end
        end
        slot = e.state_now * DEF_ACTIONS + e.action_taken;
        qcur = longint'($signed(q_table[slot]));
        td = longint'($signed(e.reward))
             + scale_q16(qmax + longint'($signed(e.potential_next)), gamma_reg)
             - qcur - longint'($signed(e.potential_now));
        v = qcur + scale_q16(td, alpha_reg);
        if (v > VALUE_MAX) begin
            v = VALUE_MAX;
        end else if (v < VALUE_MIN) begin
            v = VALUE_MIN;
        end
        q_table[slot] = v[FIX_W-1:0];
        res.new_value = v[FIX_W-1:0];
        return res;
    endfunction

    function automatic logic [FIX_W-1:0] rand_fix();
        case ($urandom_range(0, 7))
            0: return FIX_MAX;
            1: return FIX_MIN;
            2: return ($urandom_range(0, 1) != 0) ? {FIX_W{1'b1}} : {FIX_W{1'b0}};
            3, 4: return FIX_W'($urandom_range(0, 32'h20_0000) - 32'h10_0000);
            default: return FIX_W'($urandom);
        endcase
    endfunction

    // hot: keep states in a small subset so values build up
    function automatic experience_t random_experience(bit hot);
        experience_t e;
        int          ns, na, span;
        ns = eff_states();
        na = eff_actions();
        e.reward = rand_fix();
        e.potential_now = rand_fix();
        e.potential_next = rand_fix();
        if (ns == 0 || na == 0 || $urandom_range(0, 9) == 0) begin
            e.state_now = STATE_W'($urandom);
            e.action_taken = ACTION_W'($urandom);
            e.state_next = STATE_W'($urandom);
        end else begin
            span = (hot && ns > 4) ? 4 : ns;
            e.state_now = STATE_W'($urandom_range(0, span - 1));
            e.state_next = STATE_W'($urandom_range(0, span - 1));
            e.action_taken = ACTION_W'($urandom_range(0, na - 1));
        end
        return e;
    endfunction

    function automatic step_row_t item_row(logic [STATE_W-1:0] s, logic [ACTION_W-1:0] a,
                                           logic [STATE_W-1:0] sn, logic [FIX_W-1:0] r,
                                           logic [FIX_W-1:0] pn, logic [FIX_W-1:0] px);
        step_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item = '{s, a, sn, r, pn, px};
        return row;
    endfunction

    function automatic step_row_t known_row(logic [STATE_W-1:0] s, logic [ACTION_W-1:0] a,
                                            logic [STATE_W-1:0] sn, q_result_t want);
        step_row_t row;
        row = item_row(s, a, sn, '0, '0, '0);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic step_row_t cfg_row(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
        step_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_sel = sel;
        row.wdata = value;
        return row;
    endfunction

    task automatic send_experience(experience_t e, logic typed, q_result_t want);
        q_result_t predicted;
        int        gap;
        s_tdata <= {{(S_TDATA_W-EXP_W){1'b0}}, e.potential_next, e.potential_now, e.reward,
                    e.state_next, e.action_taken, e.state_now};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_experience(e);
        pending_results.push_back(typed ? want : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (sel)
            REG_LEARNING_RATE:  alpha_reg = value[COEF_W-1:0];
            REG_DISCOUNT:       gamma_reg = value[COEF_W-1:0];
            REG_STATES_IN_USE:  states_reg = value[SIU_W-1:0];
            REG_ACTIONS_IN_USE: actions_reg = value[AIU_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // receiver: random ready density per window, plus requested long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_served + 1;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            pattern_cnt <= pattern_cnt + 1'b1;
            if (pattern_cnt == '0) begin
                case ($urandom_range(0, 4))
                    0, 1: ready_pct <= 100;
                    2: ready_pct <= 75;
                    3: ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
            end
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        q_result_t got;
        q_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.new_value = m_tdata[FIX_W-1:0];
            got.best_next_action = m_tdata[FIX_W +: ACTION_W];
            got.index_error = m_tuser;
            if (pending_results.size() == 0) begin
                $error("result with no request pending: new_value %0d", $signed(got.new_value));
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.new_value !== want.new_value) begin
                    $error("new_value: expected %0d, got %0d",
                           $signed(want.new_value), $signed(got.new_value));
                    fail_count++;
                end
                if (got.best_next_action !== want.best_next_action) begin
                    $error("best_next_action: expected %0d, got %0d",
                           want.best_next_action, got.best_next_action);
                    fail_count++;
                end
                if (got.index_error !== want.index_error) begin
                    $error("index_error: expected %0b, got %0b",
                           want.index_error, got.index_error);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        step_row_t         script[$];
        logic [COEF_W-1:0] lr, dc;
        logic [SIU_W-1:0]  siu;
        logic [AIU_W-1:0]  aiu;
        foreach (q_table[i]) q_table[i] = '0;
        script = '{
            known_row(0, 0, 0, ZERO_RESULT),
            item_row(63, 3, 63, FIX_MAX, FIX_MIN, FIX_MAX),
            item_row(63, 3, 63, FIX_MIN, FIX_MAX, FIX_MIN),
            item_row(1, 2, 63, 32'h0001_0000, '0, '0),
            item_row(63, 0, 1, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_FFFF),
            cfg_row(REG_LEARNING_RATE, COEF_ONE),
            cfg_row(REG_DISCOUNT, COEF_ONE),
            item_row(5, 1, 5, FIX_MAX, FIX_MIN, FIX_MAX),
            item_row(5, 1, 5, FIX_MIN, FIX_MAX, FIX_MIN),
            cfg_row(REG_LEARNING_RATE, 17'h1_FFFF),
            cfg_row(REG_DISCOUNT, 17'h1_FFFF),
            item_row(5, 1, 5, 32'h0001_0000, '0, '0),
            cfg_row(REG_LEARNING_RATE, '0),
            item_row(5, 1, 2, FIX_MAX, '0, '0),
            cfg_row(REG_LEARNING_RATE, 17'd32768),
            cfg_row(REG_STATES_IN_USE, 17'd8),
            cfg_row(REG_ACTIONS_IN_USE, 17'd2),
            known_row(8, 0, 0, ERR_RESULT),
            known_row(0, 2, 0, ERR_RESULT),
            known_row(0, 0, 8, ERR_RESULT),
            item_row(7, 1, 7, 32'h1234_5678, 32'h0000_1000, 32'hFFFF_F000),
            cfg_row(REG_ACTIONS_IN_USE, '0),
            known_row(0, 0, 0, ERR_RESULT),
            cfg_row(REG_STATES_IN_USE, '0),
            cfg_row(REG_ACTIONS_IN_USE, 17'd4),
            known_row(0, 0, 0, ERR_RESULT),
            cfg_row(REG_STATES_IN_USE, 17'd127),
            cfg_row(REG_ACTIONS_IN_USE, 17'd7),
            item_row(63, 3, 63, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                wait_drained();
                write_reg(script[k].reg_sel, script[k].wdata);
            end else begin
                send_experience(script[k].item, script[k].typed, script[k].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    lr = RST_LR;
                    dc = RST_DISCOUNT;
                    siu = RST_STATES;
                    aiu = RST_ACTIONS;
                end
                1: begin
                    lr = '0;
                    dc = '0;
                    siu = 7'd1;
                    aiu = 3'd1;
                end
                2: begin
                    lr = COEF_ONE;
                    dc = COEF_ONE;
                    siu = 7'd2;
                    aiu = 3'd2;
                end
                3: begin
                    lr = '1;
                    dc = '1;
                    siu = '1;
                    aiu = '1;
                end
                4: begin
                    lr = 17'd32768;
                    dc = COEF_ONE;
                    siu = 7'd4;
                    aiu = 3'd3;
                end
                default: begin
                    lr = COEF_W'($urandom_range(0, 131071));
                    dc = COEF_W'($urandom_range(0, 131071));
                    siu = ($urandom_range(0, 3) == 0) ? SIU_W'($urandom_range(0, 127))
                                                      : SIU_W'($urandom_range(1, 64));
                    aiu = ($urandom_range(0, 3) == 0) ? AIU_W'($urandom_range(0, 7))
                                                      : AIU_W'($urandom_range(1, 4));
                end
            endcase
            write_reg(REG_LEARNING_RATE, lr);
            write_reg(REG_DISCOUNT, dc);
            write_reg(REG_STATES_IN_USE, CFG_DATA_W'(siu));
            write_reg(REG_ACTIONS_IN_USE, CFG_DATA_W'(aiu));
            // receiver backs off while requests keep coming
            if (phase == 0) hold_asked <= hold_asked + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == PHASE_ITEMS / 2) wait_drained();
                send_experience(random_experience(n[0]), 1'b0, ZERO_RESULT);
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/qlu_pkg.sv
rtl/core/q_learning_table_update.sv
rtl/core/qlu_checker.sv
verif/tb.sv
